[hdl/qrs_pkg.sv]
// Package for the quadratic root solver: payload widths, pipeline
// constants and the structs carried between the cells. No dependencies.
`default_nettype none
package qrs_pkg;
   localparam int COEF_WIDTH = 16;
   localparam int DISC_WIDTH = 34;
   localparam int ROOT_WIDTH = 32;
   localparam int ROOT_SHIFT = 15;
   localparam int RAD_WIDTH = 64;
   localparam int REM_WIDTH = ROOT_WIDTH + 3;
   localparam int NUM_WIDTH = 34;
   localparam int SQRT_CELLS = RAD_WIDTH / 2;
   localparam int DIV_CELLS = NUM_WIDTH;

   typedef struct packed {
      logic                    valid;
      logic                    ok;
      logic                    a_neg;
      logic [COEF_WIDTH-1:0]   a_mag;
      logic [COEF_WIDTH-1:0]   coef_b;
      logic [DISC_WIDTH-1:0]   disc;
   } side_type;

   typedef struct packed {
      side_type                side;
      logic [RAD_WIDTH-1:0]    rad;
      logic [REM_WIDTH-1:0]    rem;
      logic [ROOT_WIDTH-1:0]   root;
   } sq_type;

   typedef struct packed {
      side_type                side;
      logic                    np_neg;
      logic                    nm_neg;
      logic [NUM_WIDTH-1:0]    np;
      logic [NUM_WIDTH-1:0]    nm;
      logic [COEF_WIDTH-1:0]   rp;
      logic [COEF_WIDTH-1:0]   rm;
   } dv_type;
endpackage
`default_nettype wire

[hdl/qrs_if.sv]
// Channel interfaces for the coefficient request and the root response.
// Depends on qrs_pkg.
`default_nettype none
interface qrs_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [qrs_pkg::COEF_WIDTH-1:0] coef_a;
   logic signed [qrs_pkg::COEF_WIDTH-1:0] coef_b;
   logic signed [qrs_pkg::COEF_WIDTH-1:0] coef_c;
   modport source (output valid, coef_a, coef_b, coef_c, input ready);
   modport sink (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 roots_valid;
   logic signed [qrs_pkg::ROOT_WIDTH-1:0] root_plus;
   logic signed [qrs_pkg::ROOT_WIDTH-1:0] root_minus;
   logic signed [qrs_pkg::DISC_WIDTH-1:0] discriminant;
   modport source (output valid, roots_valid, root_plus, root_minus, discriminant,
                   input ready);
   modport sink (input valid, roots_valid, root_plus, root_minus, discriminant,
                 output ready);
endinterface
`default_nettype wire

[hdl/qrs_sqrt_cell.sv]
// One cell of the square root chain: retires two radicand bits and
// produces one root bit per stage. Depends on qrs_pkg.
`default_nettype none
module qrs_sqrt_cell (
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  qrs_pkg::sq_type cell_in,
   output qrs_pkg::sq_type cell_out
);
   import qrs_pkg::*;

   sq_type                stage_ff, stage_in;
   logic [REM_WIDTH-1:0]  rem_sh, trial;

   always_comb begin
      rem_sh = {cell_in.rem[REM_WIDTH-3:0], cell_in.rad[RAD_WIDTH-1 -: 2]};
      trial = {1'b0, cell_in.root, 2'b01};
      stage_in = cell_in;
      stage_in.rad = {cell_in.rad[RAD_WIDTH-3:0], 2'b00};
      if (rem_sh >= trial) begin
         stage_in.rem = rem_sh - trial;
         stage_in.root = {cell_in.root[ROOT_WIDTH-2:0], 1'b1};
      end else begin
         stage_in.rem = rem_sh;
         stage_in.root = {cell_in.root[ROOT_WIDTH-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.side.valid <= 1'b0;
      end else if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign cell_out = stage_ff;
endmodule
`default_nettype wire

[hdl/qrs_div_cell.sv]
// One cell of the divider chain: one quotient bit for each of the two
// numerators per stage, by restoring division. Depends on qrs_pkg.
`default_nettype none
module qrs_div_cell (
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  qrs_pkg::dv_type cell_in,
   output qrs_pkg::dv_type cell_out
);
   import qrs_pkg::*;

   dv_type                stage_ff, stage_in;
   logic [COEF_WIDTH:0]   tp, tm, dvs;

   always_comb begin
      dvs = {1'b0, cell_in.side.a_mag};
      tp = {cell_in.rp, cell_in.np[NUM_WIDTH-1]};
      tm = {cell_in.rm, cell_in.nm[NUM_WIDTH-1]};
      stage_in = cell_in;
      if (tp >= dvs) begin
         stage_in.rp = COEF_WIDTH'(tp - dvs);
         stage_in.np = {cell_in.np[NUM_WIDTH-2:0], 1'b1};
      end else begin
         stage_in.rp = tp[COEF_WIDTH-1:0];
         stage_in.np = {cell_in.np[NUM_WIDTH-2:0], 1'b0};
      end
      if (tm >= dvs) begin
         stage_in.rm = COEF_WIDTH'(tm - dvs);
         stage_in.nm = {cell_in.nm[NUM_WIDTH-2:0], 1'b1};
      end else begin
         stage_in.rm = tm[COEF_WIDTH-1:0];
         stage_in.nm = {cell_in.nm[NUM_WIDTH-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.side.valid <= 1'b0;
      end else if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign cell_out = stage_ff;
endmodule
`default_nettype wire

[hdl/quadratic_root_solver_top.sv]
// Top level of the quadratic root solver: discriminant stage, square root
// and divider cell chains, output register. Depends on qrs_pkg, qrs_if and the cells.
`default_nettype none
// The solver takes one coefficient transaction per cycle while the chain
// does not hold and returns one response transaction for each, in order,
// after the discriminant register, 32 square root cells, the numerator register,
// 34 divider cells and the output register. The whole chain advances
// together and holds only while a response waits and is not taken.
module quadratic_root_solver_top (
   input logic          clock,
   input logic          reset,
   qrs_req_if.sink      req_chan,
   qrs_rsp_if.source    rsp_chan
);
   import qrs_pkg::*;

   function automatic logic [ROOT_WIDTH-1:0] sat_root(input logic [NUM_WIDTH-1:0] mag,
                                                     input logic neg);
      logic [NUM_WIDTH-1:0] lim;
      logic [NUM_WIDTH-1:0] negv;
      lim = NUM_WIDTH'(34'h0_8000_0000);
      negv = ~mag + NUM_WIDTH'(1);
      if (neg) begin
         sat_root = (mag > lim) ? {1'b1, {(ROOT_WIDTH-1){1'b0}}} : negv[ROOT_WIDTH-1:0];
      end else begin
         sat_root = (mag >= lim) ? {1'b0, {(ROOT_WIDTH-1){1'b1}}} : mag[ROOT_WIDTH-1:0];
      end
   endfunction

   logic                         en;
   logic signed [2*COEF_WIDTH-1:0] bb, ac;
   logic signed [DISC_WIDTH-1:0]   disc;
   sq_type                       sq0_ff, sq0_in;
   sq_type                       sq_chain [0:SQRT_CELLS];
   dv_type                       dv0_ff, dv0_in;
   dv_type                       dv_chain [0:DIV_CELLS];
   logic signed [NUM_WIDTH-1:0]  nb, np, nm;
   logic                         out_valid_ff;
   logic                         out_ok_ff, out_ok_in;
   logic [ROOT_WIDTH-1:0]        out_rp_ff, out_rp_in, out_rm_ff, out_rm_in;
   logic [DISC_WIDTH-1:0]        out_disc_ff;
   dv_type                       last;

   assign en = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   always_comb begin
      bb = req_chan.coef_b * req_chan.coef_b;
      ac = req_chan.coef_a * req_chan.coef_c;
      disc = DISC_WIDTH'(bb) - (DISC_WIDTH'(ac) <<< 2);
      sq0_in = '0;
      sq0_in.side.valid = req_chan.valid;
      sq0_in.side.ok = (req_chan.coef_a != '0) && !disc[DISC_WIDTH-1] && (disc != '0);
      sq0_in.side.a_neg = req_chan.coef_a[COEF_WIDTH-1];
      sq0_in.side.a_mag = req_chan.coef_a[COEF_WIDTH-1] ? COEF_WIDTH'(-req_chan.coef_a)
                                                        : req_chan.coef_a;
      sq0_in.side.coef_b = req_chan.coef_b;
      sq0_in.side.disc = disc;
      if (sq0_in.side.ok) begin
         sq0_in.rad = {1'b0, disc[DISC_WIDTH-2:0], {(2*ROOT_SHIFT){1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq0_ff.side.valid <= 1'b0;
      end else if (en) begin
         sq0_ff <= sq0_in;
      end
   end

   assign sq_chain[0] = sq0_ff;

   for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
      qrs_sqrt_cell u_cell (
         .clock(clock), .reset(reset), .en(en),
         .cell_in(sq_chain[i]), .cell_out(sq_chain[i+1])
      );
   end

   always_comb begin
      nb = -(NUM_WIDTH'($signed(sq_chain[SQRT_CELLS].side.coef_b)) <<< ROOT_SHIFT);
      np = nb + $signed({2'b00, sq_chain[SQRT_CELLS].root});
      nm = nb - $signed({2'b00, sq_chain[SQRT_CELLS].root});
      dv0_in = '0;
      dv0_in.side = sq_chain[SQRT_CELLS].side;
      dv0_in.np_neg = np[NUM_WIDTH-1] ^ dv0_in.side.a_neg;
      dv0_in.nm_neg = nm[NUM_WIDTH-1] ^ dv0_in.side.a_neg;
      dv0_in.np = np[NUM_WIDTH-1] ? NUM_WIDTH'(-np) : np;
      dv0_in.nm = nm[NUM_WIDTH-1] ? NUM_WIDTH'(-nm) : nm;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv0_ff.side.valid <= 1'b0;
      end else if (en) begin
         dv0_ff <= dv0_in;
      end
   end

   assign dv_chain[0] = dv0_ff;

   for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
      qrs_div_cell u_cell (
         .clock(clock), .reset(reset), .en(en),
         .cell_in(dv_chain[i]), .cell_out(dv_chain[i+1])
      );
   end

   assign last = dv_chain[DIV_CELLS];

   always_comb begin
      out_ok_in = last.side.ok;
      out_rp_in = last.side.ok ? sat_root(last.np, last.np_neg) : '0;
      out_rm_in = last.side.ok ? sat_root(last.nm, last.nm_neg) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= last.side.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ok_ff <= out_ok_in;
         out_rp_ff <= out_rp_in;
         out_rm_ff <= out_rm_in;
         out_disc_ff <= last.side.disc;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.roots_valid = out_ok_ff;
   assign rsp_chan.root_plus = out_rp_ff;
   assign rsp_chan.root_minus = out_rm_ff;
   assign rsp_chan.discriminant = out_disc_ff;

   a_zero_when_invalid: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.roots_valid |->
         rsp_chan.root_plus == '0 && rsp_chan.root_minus == '0)
      else $error("Roots nonzero on a response without roots.");

   a_valid_needs_positive_disc: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.roots_valid |->
         !rsp_chan.discriminant[DISC_WIDTH-1] && rsp_chan.discriminant != '0)
      else $error("Roots reported for a discriminant that is not positive.");

   a_stall_only_on_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> rsp_chan.valid && !rsp_chan.ready)
      else $error("Request side stalled without response backpressure.");
endmodule
`default_nettype wire
